// File: rtl/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

    localparam logic [2:0] PH_HDR0   = 3'd0;
    localparam logic [2:0] PH_HDR1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_KEY    = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_DEAD   = 3'd5;

    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] EXT64_COUNT = 3'd7;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic [3:0] hdr_opcode;
        logic       frame_fin;
        logic       frame_end;
        logic       close_seen;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/wsd_parser.sv
`default_nettype none
module wsd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_rx_byte,
    output logic                 o_res_valid,
    output wsd_pkg::t_result     o_res
);
    import wsd_pkg::*;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin, n_fin;
    logic        r_mask, n_mask;
    logic [2:0]  r_hcnt, n_hcnt;
    logic [63:0] r_len, n_len;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_kidx, n_kidx;

    logic        len_done;
    logic        len_mask;
    logic        start_req;
    logic        start_zero;
    logic [6:0]  len7;
    logic [7:0]  key_byte;

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_mask   = r_mask;
        n_hcnt   = r_hcnt;
        n_len    = r_len;
        n_key    = r_key;
        n_kidx   = r_kidx;
        len_done   = 1'b0;
        len_mask   = r_mask;
        start_req  = 1'b0;
        start_zero = 1'b0;
        len7       = i_rx_byte[6:0];
        key_byte   = 8'd0;

        o_res_valid         = 1'b0;
        o_res.payload_byte  = 8'd0;
        o_res.byte_valid    = 1'b0;
        o_res.hdr_opcode    = r_opcode;
        o_res.frame_fin     = r_fin;
        o_res.frame_end     = 1'b0;
        o_res.close_seen    = 1'b0;

        case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase

        case (r_phase)
            PH_HDR0: begin
                n_opcode = i_rx_byte[3:0];
                n_fin    = i_rx_byte[7];
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_mask = i_rx_byte[7];
                if (r_opcode == OPC_CLOSE) begin
                    n_phase          = PH_DEAD;
                    o_res_valid      = 1'b1;
                    o_res.frame_end  = 1'b1;
                    o_res.close_seen = 1'b1;
                end else if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                    n_len   = 64'd0;
                    n_phase = PH_EXTLEN;
                    if (len7 == LEN_EXT64) begin
                        n_hcnt = EXT64_COUNT;
                        n_kidx = 2'd1;
                    end else begin
                        n_hcnt = EXT16_BYTES;
                        n_kidx = 2'd0;
                    end
                end else begin
                    n_len      = {57'd0, len7};
                    len_done   = 1'b1;
                    len_mask   = i_rx_byte[7];
                    start_zero = (len7 == 7'd0);
                end
            end
            PH_EXTLEN: begin
                n_len = {r_len[55:0], i_rx_byte};
                if (r_hcnt > 3'd1) begin
                    n_hcnt = r_hcnt - 3'd1;
                end else if (r_kidx[0]) begin
                    n_kidx = 2'd0;
                    n_hcnt = 3'd1;
                end else begin
                    n_hcnt     = 3'd0;
                    len_done   = 1'b1;
                    start_zero = ({r_len[55:0], i_rx_byte} == 64'd0);
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_rx_byte};
                if (r_hcnt > 3'd1) begin
                    n_hcnt = r_hcnt - 3'd1;
                end else begin
                    n_hcnt     = 3'd0;
                    start_req  = 1'b1;
                    start_zero = (r_len == 64'd0);
                end
            end
            PH_DATA: begin
                n_kidx = r_kidx + 2'd1;
                n_len  = r_len - 64'd1;
                o_res_valid        = 1'b1;
                o_res.byte_valid   = 1'b1;
                o_res.payload_byte = r_mask ? (i_rx_byte ^ key_byte) : i_rx_byte;
                if (r_len == 64'd1) begin
                    n_phase         = PH_HDR0;
                    n_kidx          = 2'd0;
                    o_res.frame_end = 1'b1;
                end
            end
            default: begin
                n_phase = PH_DEAD;
            end
        endcase

        if (len_done) begin
            if (len_mask) begin
                n_key   = 32'd0;
                n_hcnt  = KEY_BYTES;
                n_phase = PH_KEY;
            end else begin
                start_req = 1'b1;
            end
        end

        if (start_req) begin
            n_kidx = 2'd0;
            if (start_zero) begin
                n_phase         = PH_HDR0;
                o_res_valid     = 1'b1;
                o_res.frame_end = 1'b1;
            end else begin
                n_phase = PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= 4'd0;
            r_fin    <= 1'b0;
            r_mask   <= 1'b0;
            r_hcnt   <= 3'd0;
            r_len    <= 64'd0;
            r_key    <= 32'd0;
            r_kidx   <= 2'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_mask   <= n_mask;
            r_hcnt   <= n_hcnt;
            r_len    <= n_len;
            r_key    <= n_key;
            r_kidx   <= n_kidx;
        end
    end

endmodule
`default_nettype wire

// File: rtl/wsd_out_reg.sv
`default_nettype none
module wsd_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_res_valid,
    input  wire wsd_pkg::t_result i_res,
    input  wire logic            i_m_ready,
    output logic                 o_in_ready,
    output logic                 o_valid,
    output wsd_pkg::t_result     o_res
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_in_ready = !r_valid || i_m_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept && i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

// File: rtl/websocket_frame_deframer_top.sv
// WebSocket frame deframer, receive side.
// Received bytes enter one per beat on the slave stream (s_axis_tdata is the byte).
// Header bytes are parsed and dropped; each payload byte leaves on the master stream
// with its masking key byte removed, tagged with the frame's opcode and FIN bit.
// m_axis_tlast marks the last beat of a frame. An empty frame gives one beat with no
// data byte, and a close frame gives one beat with the close flag after its second
// header byte, after which every further input byte is dropped until reset.
// A result is registered at the edge that accepts its byte.
// Throughput is one byte per cycle when the receiver does not stall, set by the
// single parse stage feeding one output register; s_axis_tready stays high while
// that register is empty or being drained in the same cycle.
// When the receiver stalls with a result held, input is held off until it drains;
// bytes that give no result are still blocked then, which keeps order simple.
// Reset (synchronous, active low) returns the parser to the first header byte
// and empties the output register.
`default_nettype none
module websocket_frame_deframer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] payload_byte
    output logic            m_axis_tlast,
    output logic [6:0]      m_axis_tuser    // [0] byte_valid, [4:1] hdr_opcode,
                                            // [5] frame_fin, [6] close_seen
);
    import wsd_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_m_ready   (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res)
    );

    assign m_axis_tdata = out_res.payload_byte;
    assign m_axis_tlast = out_res.frame_end;
    assign m_axis_tuser = {out_res.close_seen, out_res.frame_fin,
                           out_res.hdr_opcode, out_res.byte_valid};

endmodule
`default_nettype wire
